@@ rtl/core/b64d_pkg.sv @@
// shared types, constants and the character lookup of the base64 stream decoder
package b64d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned StoreW  = 3 * SextetW;
  localparam int unsigned GroupW  = 4 * SextetW;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChPad   = 8'h3D;
  localparam logic [ByteW-1:0] ChDig0  = 8'h30;
  localparam logic [ByteW-1:0] ChDig9  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChLoA   = 8'h61;
  localparam logic [ByteW-1:0] ChLoZ   = 8'h7A;

  localparam logic [SextetW-1:0] SxPlus  = 6'd62;
  localparam logic [SextetW-1:0] SxSlash = 6'd63;
  localparam logic [SextetW-1:0] SxDig0  = 6'd52;
  localparam logic [SextetW-1:0] SxLoA   = 6'd26;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    status_e          status;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] num;
    result_t [MaxRes-1:0] res;
  } group_t;

  typedef struct packed {
    logic               bad;
    logic               pad;
    logic [SextetW-1:0] val;
  } sextet_t;

  function automatic sextet_t classify(input logic [ByteW-1:0] c);
    sextet_t s;
    s = '{bad: 1'b0, pad: 1'b0, val: '0};
    case (c) inside
      ChPlus:          s.val = SxPlus;
      ChSlash:         s.val = SxSlash;
      [ChDig0:ChDig9]: s.val = SextetW'(c - ChDig0) + SxDig0;
      [ChUpA:ChUpZ]:   s.val = SextetW'(c - ChUpA);
      [ChLoA:ChLoZ]:   s.val = SextetW'(c - ChLoA) + SxLoA;
      ChPad:           s.pad = 1'b1;
      default:         s.bad = 1'b1;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/b64d_decode.sv @@
// quartet state and per-character decode into a group of up to three result beats
module b64d_decode
  import b64d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] char_i,
  input  logic             eos_i,
  input  logic             advance_i,
  output group_t           group_o
);

  logic [StoreW-1:0] store_q, store_d;
  logic [1:0]        pos_q, pos_d;
  logic              pend_q, pend_d;
  logic              drop_q, drop_d;

  sextet_t           sx;
  logic [GroupW-1:0] full;
  logic              err;
  status_e           err_code;

  always_comb begin
    sx       = classify(char_i);
    full     = {store_q, (sx.pad ? '0 : sx.val)};
    err      = 1'b1;
    err_code = ST_BAD_CHAR;
    if (sx.bad) begin
      err_code = ST_BAD_CHAR;
    end else if (sx.pad && (pos_q == 2'd0 || pos_q == 2'd1)) begin
      err_code = ST_BAD_PAD;
    end else if (!sx.pad && pend_q) begin
      err_code = ST_BAD_PAD;
    end else if (pos_q != 2'd3 && eos_i) begin
      err_code = ST_BAD_LEN;
    end else if (pos_q == 2'd3 && sx.pad && !eos_i) begin
      err_code = ST_BAD_PAD;
    end else begin
      err = 1'b0;
    end

    group_o = '0;
    store_d = store_q;
    pos_d   = pos_q;
    pend_d  = pend_q;
    drop_d  = drop_q;

    if (drop_q) begin
      if (eos_i) begin
        store_d = '0;
        pos_d   = '0;
        pend_d  = 1'b0;
        drop_d  = 1'b0;
      end
    end else if (err) begin
      group_o.num           = CntW'(1);
      group_o.res[0].status = err_code;
      group_o.res[0].last   = 1'b1;
      store_d = '0;
      pos_d   = '0;
      pend_d  = 1'b0;
      drop_d  = !eos_i;
    end else if (pos_q != 2'd3) begin
      store_d = {store_q[StoreW-SextetW-1:0], (sx.pad ? '0 : sx.val)};
      pos_d   = pos_q + 2'd1;
      pend_d  = pend_q | sx.pad;
    end else begin
      group_o.num = sx.pad ? (pend_q ? CntW'(1) : CntW'(2)) : CntW'(3);
      group_o.res[0].data_byte = full[23:16];
      group_o.res[1].data_byte = full[15:8];
      group_o.res[2].data_byte = full[7:0];
      for (int k = 0; k < MaxRes; k++) begin
        group_o.res[k].status = ST_DATA;
        group_o.res[k].last   = eos_i && (CntW'(k + 1) == group_o.num);
      end
      store_d = '0;
      pos_d   = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      pos_q   <= '0;
      pend_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else if (advance_i) begin
      store_q <= store_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      drop_q  <= drop_d;
    end
  end

  a_err_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (group_o.num != '0 && group_o.res[0].status != ST_DATA)
      |-> (group_o.num == CntW'(1) && group_o.res[0].last))
    else $error("error beat not single or not marked last");

  a_drop_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && drop_q && eos_i) |=> (!drop_q && pos_q == 2'd0 && !pend_q))
    else $error("end of stream in drop mode did not clear state");

  a_pend_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> pos_q == 2'd3)
    else $error("pad pending outside last place of quartet");

endmodule

@@ rtl/core/b64d_out_buf.sv @@
// three-beat output buffer that takes a whole result group and drains one beat per cycle while downstream is ready
module b64d_out_buf
  import b64d_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  group_t group_i,
  input  logic   push_i,
  output logic   fits_o,
  output logic   valid_o,
  output result_t head_o,
  input  logic   ready_i
);

  result_t [MaxRes-1:0] buf_q, buf_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pop;
  logic [CntW-1:0]      cnt_pop;
  logic [CntW:0]        total;
  logic [CntW-1:0]      idx;

  assign valid_o = (cnt_q != '0);
  assign head_o  = buf_q[0];
  assign pop     = valid_o && ready_i;
  assign cnt_pop = cnt_q - CntW'(pop);
  assign total   = {1'b0, cnt_pop} + {1'b0, group_i.num};
  assign fits_o  = (total <= (CntW + 1)'(MaxRes));

  always_comb begin
    buf_d = buf_q;
    idx   = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (pop) begin
        buf_d[i] = (i < MaxRes - 1) ? buf_q[(i + 1) % MaxRes] : buf_q[i];
      end
      idx = CntW'(i) - cnt_pop;
      if (push_i && CntW'(i) >= cnt_pop && (CntW + 1)'(i) < total) begin
        buf_d[i] = group_i.res[idx];
      end
    end
    cnt_d = push_i ? total[CntW-1:0] : cnt_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> fits_o)
    else $error("group pushed into buffer without room");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("buffer count wrong after drain");

endmodule

@@ rtl/core/base64_stream_decoder_top.sv @@
// top level of the streaming base64 decoder: input register, decode and output buffer
// Decodes standard-alphabet base64 one character per beat, with s_axis_tlast marking the
// final character of a stream. A complete quartet gives three bytes, or two or one when it
// ends in '=' or '=='; the last byte of a stream has m_axis_tlast set. An error gives a
// single beat with a nonzero status in m_axis_tuser and tlast set, after which characters
// are dropped until the end of the stream. One character is accepted per cycle; the
// results of a character pass through the input register and then the output buffer
// before they reach the output. The three-beat output buffer drains one byte per cycle,
// so the input stalls only when a downstream stall leaves no room for the next group of
// results.
module base64_stream_decoder_top
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  output logic       m_axis_tlast_o
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_char_q;
  logic             in_eos_q;
  logic             accept;
  logic             advance;
  logic             fits;
  group_t           group;
  result_t          head;

  assign advance         = in_valid_q && fits;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_char_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
  end

  b64d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (in_char_q),
    .eos_i     (in_eos_q),
    .advance_i (advance),
    .group_o   (group)
  );

  b64d_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .group_i (group),
    .push_i  (advance),
    .fits_o  (fits),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = head.data_byte;
  assign m_axis_tuser_o = head.status;
  assign m_axis_tlast_o = head.last;

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_char_q) && $stable(in_eos_q)))
    else $error("held character lost while output buffer full");

endmodule

@@ test/tb_base64_stream_decoder_top.sv @@
// self-checking testbench for the streaming base64 decoder with its own decode predictor
module tb_base64_stream_decoder_top;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandItems  = 220;
  localparam int unsigned IdlePct    = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid = 1'b0;
  logic [7:0] in_char  = '0;
  logic       in_eos   = 1'b0;
  logic       out_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  char_beat_t char_q[$];
  result_t    pending_bytes[$];

  // predictor state
  logic [17:0] sextets    = '0;
  logic [1:0]  quartet_at = '0;
  logic        pad_seen   = 1'b0;
  logic        dropping   = 1'b0;

  bit          in_taken   = 1'b0;
  int unsigned cycles     = 0;
  int unsigned chars_in   = 0;
  int unsigned streams_in = 0;
  int unsigned bytes_out  = 0;
  int unsigned err_count  = 0;
  int unsigned status_seen[4];
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  logic        calm;

  base64_stream_decoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_char),
    .s_axis_tlast_i  (in_eos),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  assign calm = (chars_in >= 140) && (chars_in < 190);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    err_count++;
  endtask

  task automatic clear_stream();
    sextets    = '0;
    quartet_at = '0;
    pad_seen   = 1'b0;
    dropping   = 1'b0;
  endtask

  task automatic flag_error(input status_e code, input logic eos);
    result_t r;
    r.data_byte = '0;
    r.status    = code;
    r.last      = 1'b1;
    pending_bytes.push_back(r);
    clear_stream();
    if (!eos) begin
      dropping = 1'b1;
    end
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic eos);
    logic [5:0]  sx;
    logic        is_pad;
    logic        is_bad;
    logic [23:0] grp;
    int          nb;
    result_t     r;
    sx     = '0;
    is_pad = 1'b0;
    is_bad = 1'b0;
    if (dropping) begin
      if (eos) begin
        clear_stream();
      end
      return;
    end
    if (ch == ChPlus) begin
      sx = SxPlus;
    end else if (ch == ChSlash) begin
      sx = SxSlash;
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      sx = 6'(ch - ChDig0) + SxDig0;
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      sx = 6'(ch - ChUpA);
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      sx = 6'(ch - ChLoA) + SxLoA;
    end else if (ch == ChPad) begin
      is_pad = 1'b1;
    end else begin
      is_bad = 1'b1;
    end
    if (is_bad) begin
      flag_error(ST_BAD_CHAR, eos);
      return;
    end
    if ((is_pad && quartet_at < 2) || (!is_pad && pad_seen)) begin
      flag_error(ST_BAD_PAD, eos);
      return;
    end
    if (quartet_at < 3) begin
      pad_seen   = pad_seen | is_pad;
      sextets    = {sextets[11:0], (is_pad ? 6'd0 : sx)};
      quartet_at = quartet_at + 2'd1;
      if (eos) begin
        flag_error(ST_BAD_LEN, 1'b1);
      end
      return;
    end
    if (is_pad) begin
      if (!eos) begin
        flag_error(ST_BAD_PAD, 1'b0);
        return;
      end
      nb = pad_seen ? 1 : 2;
      sx = '0;
    end else begin
      nb = 3;
    end
    grp = {sextets, sx};
    for (int k = 0; k < nb; k++) begin
      r.data_byte = grp[23-8*k -: 8];
      r.status    = ST_DATA;
      r.last      = eos && (k == nb - 1);
      pending_bytes.push_back(r);
    end
    clear_stream();
  endtask

  function automatic logic [7:0] alphabet_char(input int unsigned idx);
    if (idx < 26) begin
      return ChUpA + 8'(idx);
    end else if (idx < 52) begin
      return ChLoA + 8'(idx - 26);
    end else if (idx < 62) begin
      return ChDig0 + 8'(idx - 52);
    end else if (idx == 62) begin
      return ChPlus;
    end
    return ChSlash;
  endfunction

  task automatic add_char(input logic [7:0] ch, input logic eos);
    char_beat_t b;
    b.ch  = ch;
    b.eos = eos;
    char_q.push_back(b);
  endtask

  task automatic add_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i], eos_last && (i == s.len() - 1));
    end
  endtask

  // mostly well-formed streams, about a quarter of them broken on purpose
  task automatic add_random_stream();
    char_beat_t s[$];
    char_beat_t b;
    int         nq;
    int         pads;
    int         pos;
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      pads = (q == nq - 1) ? $urandom_range(0, 2) : 0;
      for (int j = 0; j < 4; j++) begin
        b.ch  = (j >= 4 - pads) ? ChPad : alphabet_char($urandom_range(0, 63));
        b.eos = 1'b0;
        s.push_back(b);
      end
    end
    s[s.size()-1].eos = 1'b1;
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 3))
        0: s[pos].ch = 8'($urandom_range(0, 255));
        1: s[pos].ch = ChPad;
        2: begin
          void'(s.pop_back());
          s[s.size()-1].eos = 1'b1;
        end
        default: s[pos].eos = 1'b1;
      endcase
    end
    foreach (s[i]) begin
      char_q.push_back(s[i]);
    end
  endtask

  // sender: holds a beat until taken, gaps only between beats
  always @(negedge clk_i) begin : drive
    char_beat_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (char_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        nxt = char_q.pop_front();
        in_valid <= 1'b1;
        in_char  <= nxt.ch;
        in_eos   <= nxt.eos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin : sink
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (!hold_done && chars_in >= 60) begin
      hold_done <= 1'b1;
      hold_left <= 150;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : watch
    result_t want;
    in_taken <= in_valid && s_axis_tready_o;
    if (rst_ni && in_valid && s_axis_tready_o) begin
      decode_char(in_char, in_eos);
      chars_in++;
      if (in_eos) begin
        streams_in++;
      end
    end
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      status_seen[m_axis_tuser_o]++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("beat with nothing pending, data", m_axis_tdata_o, -1);
      end else begin
        want = pending_bytes.pop_front();
        if (want.status == ST_DATA) begin
          bytes_out++;
        end
        if (m_axis_tdata_o !== want.data_byte) begin
          report_mismatch("data byte", m_axis_tdata_o, want.data_byte);
        end
        if (m_axis_tuser_o !== want.status) begin
          report_mismatch("status", m_axis_tuser_o, want.status);
        end
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch("last", m_axis_tlast_o, want.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst_ni = 1'b0;
    foreach (status_seen[i]) begin
      status_seen[i] = 0;
    end
    // alphabet extremes, then a short tail after two full quartets
    add_text("AZaz09+/Q", 1'b1);
    // padded endings with nonzero unused bits
    add_text("TR==", 1'b1);
    add_text("TWF=", 1'b1);
    // bad character on the end beat
    add_char(8'hFF, 1'b1);
    // early pad, then a dropped byte that ends the stream
    add_text("=", 1'b0);
    add_char(8'h00, 1'b1);
    add_text("A=", 1'b1);
    // data after pad
    add_text("AB=C", 1'b1);
    // padded quartet that is not the last one
    add_text("AB==", 1'b0);
    add_text("Q", 1'b1);
    while (char_q.size() < RandItems) begin
      add_random_stream();
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (char_q.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    n = 0;
    while (pending_bytes.size() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      report_mismatch("results never delivered, count", 0, pending_bytes.size());
    end
    $display("decoded %0d characters over %0d streams into %0d bytes", chars_in, streams_in,
             bytes_out);
    $display("error beats: bad char %0d, bad pad %0d, bad length %0d; mismatches %0d",
             status_seen[ST_BAD_CHAR], status_seen[ST_BAD_PAD], status_seen[ST_BAD_LEN],
             err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/b64d_pkg.sv
rtl/core/b64d_decode.sv
rtl/core/b64d_out_buf.sv
rtl/core/base64_stream_decoder_top.sv
test/tb_base64_stream_decoder_top.sv
